### hw/rtl/sttu_pkg.sv
// Package for the software timer table unit.
// Holds request and result codes, default sizes and the result record type.
// Used by sttu_seq, sttu_out_reg and the top level; depends on nothing.
`timescale 1ns / 1ps

package sttu_pkg;

  localparam int SLOTS_DEF    = 8;
  localparam int TAG_BITS_DEF = 16;
  localparam int MAX_RESULTS  = 8;
  localparam int FIRE_CNT_W   = 4;

  localparam logic [1:0] REQ_CREATE  = 2'd0;
  localparam logic [1:0] REQ_DELETE  = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;
  localparam logic [1:0] REQ_SERVICE = 2'd3;

  localparam logic [2:0] EV_CREATED   = 3'd0;
  localparam logic [2:0] EV_FULL      = 3'd1;
  localparam logic [2:0] EV_DELETED   = 3'd2;
  localparam logic [2:0] EV_NOT_FOUND = 3'd3;
  localparam logic [2:0] EV_TICK_DONE = 3'd4;
  localparam logic [2:0] EV_FIRED     = 3'd5;
  localparam logic [2:0] EV_NONE      = 3'd6;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [5:0]  slot;
    logic [15:0] fired_tag;
    logic        last;
  } res_t;

endpackage

### hw/rtl/sttu_slot_mem.sv
// Slot entry memory of the software timer table unit.
// One write port and one registered read port; depends on nothing.
`timescale 1ns / 1ps

module sttu_slot_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 50,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sttu_out_reg.sv
// Output register of the software timer table unit.
// Holds one result record until the receiver takes it; uses sttu_pkg.
`timescale 1ns / 1ps

module sttu_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sttu_pkg::res_t res,
  output logic          ready,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [2:0]    event_res,
  output logic [5:0]    slot,
  output logic [15:0]   fired_tag,
  output logic          last
);

  sttu_pkg::res_t held;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

  assign event_res = held.event_res;
  assign slot      = held.slot;
  assign fired_tag = held.fired_tag;
  assign last      = held.last;

endmodule

### hw/rtl/sttu_seq.sv
// Request sequencer of the software timer table unit.
// Walks the slots one at a time through the shared compare and decrement
// logic; uses sttu_pkg and drives the ports of sttu_slot_mem.
`timescale 1ns / 1ps

module sttu_seq #(
  parameter int SLOTS    = sttu_pkg::SLOTS_DEF,
  parameter int TAG_BITS = sttu_pkg::TAG_BITS_DEF,
  parameter int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int ENT_W    = TAG_BITS + 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             busy,
  input  logic [1:0]       req_type,
  input  logic [15:0]      tag,
  input  logic [15:0]      period,
  input  logic             periodic,
  input  logic             has_handler,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output logic [ENT_W-1:0] mem_wdata,
  output logic [IDX_W-1:0] mem_raddr,
  input  logic [ENT_W-1:0] mem_rdata,
  output sttu_pkg::res_t   res,
  output logic             res_valid,
  input  logic             res_ready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam int HH_B  = 0;
  localparam int PER_B = 1;
  localparam int REM_L = 2;
  localparam int PRD_L = 18;
  localparam int TAG_L = 34;

  logic [2:0]          state;
  logic [2:0]          ret_state;
  logic [IDX_W-1:0]    idx;
  logic [SLOTS-1:0]    enabled;
  logic [1:0]          req_r;
  logic [TAG_BITS-1:0] tg_r;
  logic [15:0]         period_r;
  logic                periodic_r;
  logic                hh_r;
  logic                match_f;
  logic [IDX_W-1:0]    match_idx;
  logic                free_f;
  logic [IDX_W-1:0]    free_idx;
  logic                pend_v;
  sttu_pkg::res_t      pend;
  logic [sttu_pkg::FIRE_CNT_W-1:0] nfired;

  logic [TAG_BITS-1:0] rtag;
  logic [15:0]         rrem;
  logic [15:0]         rprd;
  logic                ren;
  logic                hit;
  logic                fire;
  logic                done;
  logic [IDX_W-1:0]    sel_idx;

  assign busy = (state != S_IDLE);

  assign rtag    = mem_rdata[TAG_L +: TAG_BITS];
  assign rprd    = mem_rdata[PRD_L +: 16];
  assign rrem    = mem_rdata[REM_L +: 16];
  assign ren     = enabled[idx];
  assign hit     = ren && (rtag == tg_r);
  assign fire    = (req_r == sttu_pkg::REQ_SERVICE) && ren && (rrem == 16'd0)
                   && mem_rdata[HH_B];
  assign done    = (idx == IDX_W'(SLOTS - 1))
                   || (fire && (nfired == sttu_pkg::FIRE_CNT_W'(sttu_pkg::MAX_RESULTS - 1)));
  assign sel_idx = match_f ? match_idx : free_idx;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = mem_rdata;
    mem_raddr = idx;
    case (state)
      S_EV: begin
        if (req_r == sttu_pkg::REQ_TICK && ren && rrem != 16'd0) begin
          mem_we = 1'b1;
          mem_wdata[REM_L +: 16] = rrem - 16'd1;
        end else if (fire && mem_rdata[PER_B]) begin
          mem_we = 1'b1;
          mem_wdata[REM_L +: 16] = rprd;
        end
      end
      S_FIN: begin
        if (req_r == sttu_pkg::REQ_CREATE && (match_f || free_f)) begin
          mem_we    = 1'b1;
          mem_waddr = sel_idx;
          mem_wdata = {tg_r, period_r, period_r, periodic_r, hh_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      enabled   <= '0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_r      <= req_type;
            tg_r       <= TAG_BITS'(tag);
            period_r   <= period;
            periodic_r <= periodic;
            hh_r       <= has_handler;
            idx        <= '0;
            match_f    <= 1'b0;
            free_f     <= 1'b0;
            pend_v     <= 1'b0;
            nfired     <= '0;
            state      <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          case (req_r)
            sttu_pkg::REQ_CREATE: begin
              if (hit && !match_f) begin
                match_f   <= 1'b1;
                match_idx <= idx;
              end
              if (!ren && !free_f) begin
                free_f   <= 1'b1;
                free_idx <= idx;
              end
            end
            sttu_pkg::REQ_DELETE: begin
              if (hit && !match_f) begin
                match_f      <= 1'b1;
                match_idx    <= idx;
                enabled[idx] <= 1'b0;
              end
            end
            sttu_pkg::REQ_SERVICE: begin
              if (fire) begin
                if (!mem_rdata[PER_B]) begin
                  enabled[idx] <= 1'b0;
                end
                nfired <= nfired + 1'b1;
                pend   <= '{event_res: sttu_pkg::EV_FIRED, slot: 6'(idx),
                            fired_tag: 16'(rtag), last: 1'b0};
                pend_v <= 1'b1;
                if (pend_v) begin
                  res       <= pend;
                  res_valid <= 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          if (!done) begin
            idx <= IDX_W'(idx + 1'b1);
          end
          if (fire && pend_v) begin
            state     <= S_EMIT;
            ret_state <= done ? S_FIN : S_RD;
          end else begin
            state <= done ? S_FIN : S_RD;
          end
        end
        S_FIN: begin
          res.last <= 1'b1;
          case (req_r)
            sttu_pkg::REQ_CREATE: begin
              if (match_f || free_f) begin
                enabled[sel_idx] <= 1'b1;
                res.event_res    <= sttu_pkg::EV_CREATED;
                res.slot         <= 6'(sel_idx);
                res.fired_tag    <= 16'(tg_r);
              end else begin
                res.event_res <= sttu_pkg::EV_FULL;
                res.slot      <= 6'd0;
                res.fired_tag <= 16'd0;
              end
            end
            sttu_pkg::REQ_DELETE: begin
              res.event_res <= match_f ? sttu_pkg::EV_DELETED : sttu_pkg::EV_NOT_FOUND;
              res.slot      <= match_f ? 6'(match_idx) : 6'd0;
              res.fired_tag <= match_f ? 16'(tg_r) : 16'd0;
            end
            sttu_pkg::REQ_TICK: begin
              res.event_res <= sttu_pkg::EV_TICK_DONE;
              res.slot      <= 6'd0;
              res.fired_tag <= 16'd0;
            end
            default: begin
              res.event_res <= pend_v ? pend.event_res : sttu_pkg::EV_NONE;
              res.slot      <= pend_v ? pend.slot : 6'd0;
              res.fired_tag <= pend_v ? pend.fired_tag : 16'd0;
            end
          endcase
          res_valid <= 1'b1;
          ret_state <= S_IDLE;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= ret_state;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/software_timer_table_unit.sv
// Top level of the software timer table unit.
// Connects sttu_seq, sttu_slot_mem and sttu_out_reg; uses sttu_pkg.
//
// Requests arrive on the input channel (in_valid, in_stall) and results
// leave on the output channel (out_valid, out_stall); a transfer happens at
// a clock edge with valid high and stall low. Create, delete and tick give
// one result each; service gives one result for each fired slot, up to
// eight, or a single "nothing fired" result. The last result of a request
// has last set.
// The block takes one request at a time. A request walks the SLOTS entries
// through the shared compare and update logic, a read state and an
// evaluate state per slot because the slot memory read is registered, then
// a closing state and an emit state that loads the final result into the
// output register; each earlier fire result of a service request has an
// emit state of its own, and a service walk ends once eight slots have fired.
// in_stall is high for that whole time; a new request can be taken while
// the final result of the previous one waits in the output register.
// When out_stall holds a result back, the sequencer waits for the output
// register and the slot walk pauses.
// Synchronous reset disables every slot and empties the output register.
`timescale 1ns / 1ps

module software_timer_table_unit #(
  parameter int SLOTS    = sttu_pkg::SLOTS_DEF,
  parameter int TAG_BITS = sttu_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] tag,
  input  logic [15:0] period,
  input  logic        periodic,
  input  logic        has_handler,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [5:0]  slot,
  output logic [15:0] fired_tag,
  output logic        last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENT_W = TAG_BITS + 34;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENT_W-1:0] mem_rdata;
  sttu_pkg::res_t   res;
  logic             res_valid;
  logic             res_ready;
  logic             res_push;

  assign res_push = res_valid && res_ready;

  sttu_seq #(
    .SLOTS    (SLOTS),
    .TAG_BITS (TAG_BITS),
    .IDX_W    (IDX_W),
    .ENT_W    (ENT_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .busy        (in_stall),
    .req_type    (req_type),
    .tag         (tag),
    .period      (period),
    .periodic    (periodic),
    .has_handler (has_handler),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .res         (res),
    .res_valid   (res_valid),
    .res_ready   (res_ready)
  );

  sttu_slot_mem #(
    .DEPTH (SLOTS),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sttu_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .res       (res),
    .ready     (res_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .event_res (event_res),
    .slot      (slot),
    .fired_tag (fired_tag),
    .last      (last)
  );

  a_push_into_free: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (!out_valid || !out_stall))
    else $error("Result loaded while the output register was still held.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Request transfer did not start a slot walk.");

  a_idle_after_final: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last) |=> !in_stall)
    else $error("Sequencer did not return to idle after the final result.");

  a_out_follows_push: assert property (@(posedge clk) disable iff (rst)
    res_push |=> out_valid)
    else $error("Loaded result is not presented on the output channel.");

endmodule
